@@ hdl/h264_annexb_nal_splitter_core_assert.svh @@
// Assertion macros used by the checker file.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef H264_ANNEXB_NAL_SPLITTER_CORE_ASSERT_SVH
`define H264_ANNEXB_NAL_SPLITTER_CORE_ASSERT_SVH

// Check the consequent in the same cycle, off while reset is high.
`define H264NAL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check the consequent in the next cycle, off while reset is high.
`define H264NAL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Check the consequent in the next cycle, active during reset too.
`define H264NAL_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/h264nal_pkg.sv @@
package h264nal_pkg;

   localparam int BYTE_W      = 8;
   localparam int TYPE_W      = 5;
   localparam int BATCH_DEPTH = 4;
   localparam int COUNT_W     = 3;

   localparam logic [BYTE_W-1:0]  ZERO_BYTE    = 8'h00;
   localparam logic [BYTE_W-1:0]  START_BYTE   = 8'h01;
   localparam logic [TYPE_W-1:0]  TYPE_MASK    = 5'h1f;
   localparam logic [1:0]         ZERO_RUN_MAX = 2'd2;
   localparam logic [COUNT_W-1:0] HELD_MAX     = 3'd4;

   // Results produced by one input transaction, handed to the result buffer
   typedef struct packed {
      logic [COUNT_W-1:0]                  count;
      logic [BATCH_DEPTH-1:0][BYTE_W-1:0] bytes;
      logic [TYPE_W-1:0]                   unit_type;
      logic                                first;
      logic                                last;
   } batch_type;

endpackage

@@ hdl/h264nal_ifs.sv @@
interface h264nal_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface h264nal_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [4:0] unit_type;
   logic       unit_first;
   logic       unit_last;
   logic       run_end;

   modport source (output valid, output payload_byte, output unit_type,
                   output unit_first, output unit_last, output run_end, input ready);
   modport sink   (input valid, input payload_byte, input unit_type,
                   input unit_first, input unit_last, input run_end, output ready);
endinterface

@@ hdl/h264nal_parser.sv @@
module h264nal_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [h264nal_pkg::BYTE_W-1:0]      data_byte,
   input  logic                                buffer_end,
   output h264nal_pkg::batch_type              batch
);

   logic                               inside_ff, inside_in;
   logic                               expect_ff, expect_in;
   logic [1:0]                         zero_run_ff, zero_run_in;
   logic [h264nal_pkg::TYPE_W-1:0]     type_ff, type_in;
   logic [h264nal_pkg::COUNT_W-1:0]    held_count_ff, held_count_in;
   logic [h264nal_pkg::BYTE_W-1:0]     held_byte_ff, held_byte_in;

   logic                               start_seen;
   logic                               lead_nonzero;
   logic [h264nal_pkg::BYTE_W-1:0]     lead;
   logic [h264nal_pkg::COUNT_W-1:0]    cnt;
   logic [h264nal_pkg::COUNT_W-1:0]    cnt_last;
   logic                               last;
   logic                               tail_is_data;

   // Only the oldest held byte can be nonzero; the rest are implied zeros
   assign lead         = (held_count_ff == '0) ? data_byte : held_byte_ff;
   assign lead_nonzero = (held_byte_ff != h264nal_pkg::ZERO_BYTE);
   assign start_seen   = (data_byte == h264nal_pkg::START_BYTE) &&
                         ((held_count_ff == h264nal_pkg::HELD_MAX) ||
                          (held_count_ff == 3'd3) ||
                          ((held_count_ff == 3'd2) && !lead_nonzero));

   // Decide results and next parser state
   always_comb begin
      inside_in     = inside_ff;
      expect_in     = expect_ff;
      zero_run_in   = zero_run_ff;
      type_in       = type_ff;
      held_count_in = held_count_ff;
      held_byte_in  = held_byte_ff;
      cnt           = '0;
      last          = 1'b0;
      tail_is_data  = 1'b0;

      if (!inside_ff) begin
         // Search for the first start code
         priority if ((data_byte == h264nal_pkg::START_BYTE) &&
                      (zero_run_ff == h264nal_pkg::ZERO_RUN_MAX)) begin
            inside_in     = 1'b1;
            expect_in     = 1'b1;
            held_count_in = '0;
            zero_run_in   = '0;
         end else if (data_byte == h264nal_pkg::ZERO_BYTE) begin
            if (zero_run_ff != h264nal_pkg::ZERO_RUN_MAX) begin
               zero_run_in = zero_run_ff + 2'd1;
            end
         end else begin
            zero_run_in = '0;
         end
      end else begin
         priority if (start_seen) begin
            // Close the unit; trim up to one zero ahead of the start code
            if ((held_count_ff == h264nal_pkg::HELD_MAX) ||
                ((held_count_ff == 3'd3) && lead_nonzero)) begin
               cnt  = 3'd1;
               last = 1'b1;
            end
            held_count_in = '0;
         end else if (buffer_end) begin
            // Flush everything held plus the new byte; drop one zero if overfull
            cnt          = (held_count_ff >= 3'd3) ? h264nal_pkg::HELD_MAX
                                                   : held_count_ff + 3'd1;
            last         = 1'b1;
            tail_is_data = 1'b1;
         end else if (data_byte != h264nal_pkg::ZERO_BYTE) begin
            // Release the held bytes, hold the new one
            cnt           = held_count_ff;
            held_count_in = 3'd1;
            held_byte_in  = data_byte;
         end else if (held_count_ff == h264nal_pkg::HELD_MAX) begin
            // Window full and new byte zero: release the oldest byte
            cnt          = 3'd1;
            held_byte_in = h264nal_pkg::ZERO_BYTE;
         end else begin
            held_count_in = held_count_ff + 3'd1;
            if (held_count_ff == '0) begin
               held_byte_in = data_byte;
            end
         end

         if (cnt != '0) begin
            expect_in = 1'b0;
            type_in   = batch.unit_type;
         end
         if (start_seen) begin
            expect_in = 1'b1;
         end
      end

      // Buffer end returns the parser to its reset state
      if (buffer_end) begin
         inside_in     = 1'b0;
         expect_in     = 1'b0;
         zero_run_in   = '0;
         type_in       = '0;
         held_count_in = '0;
      end
   end

   // Build the result list
   assign cnt_last = cnt - 3'd1;

   always_comb begin
      batch.count     = cnt;
      batch.last      = last;
      batch.first     = expect_ff && (cnt != '0);
      batch.unit_type = expect_ff ? (lead[h264nal_pkg::TYPE_W-1:0] & h264nal_pkg::TYPE_MASK)
                                  : type_ff;
      for (int i = 0; i < h264nal_pkg::BATCH_DEPTH; i++) begin
         if (i == 0) begin
            batch.bytes[i] = lead;
         end else if (tail_is_data && (cnt_last == i[h264nal_pkg::COUNT_W-1:0])) begin
            batch.bytes[i] = data_byte;
         end else begin
            batch.bytes[i] = h264nal_pkg::ZERO_BYTE;
         end
      end
   end

   // Advance parser state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff     <= 1'b0;
         expect_ff     <= 1'b0;
         zero_run_ff   <= '0;
         type_ff       <= '0;
         held_count_ff <= '0;
      end else if (accept) begin
         inside_ff     <= inside_in;
         expect_ff     <= expect_in;
         zero_run_ff   <= zero_run_in;
         type_ff       <= type_in;
         held_count_ff <= held_count_in;
      end
   end

   // Held byte carries payload only
   always_ff @(posedge clock) begin
      if (accept) begin
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

@@ hdl/h264nal_batch.sv @@
module h264nal_batch (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  h264nal_pkg::batch_type           batch,
   output logic                             load_ready,
   input  logic                             out_ready,
   output logic                             out_valid,
   output logic [h264nal_pkg::BYTE_W-1:0]   out_byte,
   output logic [h264nal_pkg::TYPE_W-1:0]   out_type,
   output logic                             out_first,
   output logic                             out_last,
   output logic                             out_end
);

   logic [h264nal_pkg::BATCH_DEPTH-1:0][h264nal_pkg::BYTE_W-1:0] bytes_ff, bytes_in;
   logic [h264nal_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [h264nal_pkg::TYPE_W-1:0]    type_ff, type_in;
   logic                              first_ff, first_in;
   logic                              last_ff, last_in;

   logic                              out_valid_ff, out_valid_in;
   logic [h264nal_pkg::BYTE_W-1:0]    out_byte_ff, out_byte_in;
   logic [h264nal_pkg::TYPE_W-1:0]    out_type_ff, out_type_in;
   logic                              out_first_ff, out_first_in;
   logic                              out_last_ff, out_last_in;
   logic                              out_end_ff, out_end_in;

   logic                              take;
   logic                              final_entry;

   assign take        = !out_valid_ff || out_ready;
   assign final_entry = (count_ff == 3'd1);
   assign load_ready  = (count_ff == '0) || (final_entry && take);

   // Refill the output register from the head of the buffer
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_type_in  = out_type_ff;
      out_first_in = out_first_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (take) begin
         out_valid_in = (count_ff != '0);
         out_byte_in  = bytes_ff[0];
         out_type_in  = type_ff;
         out_first_in = first_ff;
         out_last_in  = last_ff && final_entry;
         out_end_in   = final_entry;
      end
   end

   // Load a new list or shift the current one down
   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      type_in  = type_ff;
      first_in = first_ff;
      last_in  = last_ff;
      priority if (load) begin
         bytes_in = batch.bytes;
         count_in = batch.count;
         type_in  = batch.unit_type;
         first_in = batch.first;
         last_in  = batch.last;
      end else if (take && (count_ff != '0)) begin
         for (int i = 0; i < h264nal_pkg::BATCH_DEPTH - 1; i++) begin
            bytes_in[i] = bytes_ff[i+1];
         end
         count_in = count_ff - 3'd1;
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bytes_ff     <= bytes_in;
      type_ff      <= type_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      out_byte_ff  <= out_byte_in;
      out_type_ff  <= out_type_in;
      out_first_ff <= out_first_in;
      out_last_ff  <= out_last_in;
      out_end_ff   <= out_end_in;
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_type  = out_type_ff;
   assign out_first = out_first_ff;
   assign out_last  = out_last_ff;
   assign out_end   = out_end_ff;

endmodule

@@ hdl/h264_annexb_nal_splitter_core.sv @@
// Channel   Modport  Carries
// req_if    sink     data_byte, buffer_end: one stream byte per transaction
// rsp_if    source   payload_byte, unit_type, unit_first, unit_last, run_end
//
// One input byte is taken per cycle while req_if.ready is high; it yields
// zero to four result bytes. Results leave one per cycle while rsp_if is
// ready, via the result buffer and the output register; an input with
// more than one result holds req_if.ready low while the buffer drains.
// Reset is synchronous and clears the parser and both result stages.
// A stall on rsp_if holds the output register; input is taken meanwhile
// until the result buffer is occupied.
module h264_annexb_nal_splitter_core (
   input  logic         clock,
   input  logic         reset,
   h264nal_req_if.sink  req_if,
   h264nal_rsp_if.source rsp_if
);

   h264nal_pkg::batch_type batch;
   logic                   accept;
   logic                   load_ready;

   assign req_if.ready = load_ready;
   assign accept       = req_if.valid && load_ready;

   // Parse the byte stream into result lists
   h264nal_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_if.data_byte),
      .buffer_end (req_if.buffer_end),
      .batch      (batch)
   );

   // Buffer result lists and issue one result per transaction
   h264nal_batch u_batch (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .batch      (batch),
      .load_ready (load_ready),
      .out_ready  (rsp_if.ready),
      .out_valid  (rsp_if.valid),
      .out_byte   (rsp_if.payload_byte),
      .out_type   (rsp_if.unit_type),
      .out_first  (rsp_if.unit_first),
      .out_last   (rsp_if.unit_last),
      .out_end    (rsp_if.run_end)
   );

endmodule

@@ hdl/h264nal_checker.sv @@
`include "h264_annexb_nal_splitter_core_assert.svh"

module h264nal_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] payload_byte,
   input logic [4:0] unit_type,
   input logic       unit_first,
   input logic       unit_last,
   input logic       run_end
);

   // Stalled result holds its payload
   `H264NAL_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(payload_byte) && $stable(unit_type) && $stable(run_end), "stalled result changed")

   // Result output is empty after reset
   `H264NAL_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid after reset")

   // A unit ends only on the last result of a run
   `H264NAL_ASSERT_SAME(a_last_on_end, rsp_valid && unit_last, run_end, "unit end inside a run")

   // A run continues next cycle with the same type and no header mark
   `H264NAL_ASSERT_NEXT(a_run_follows, rsp_valid && rsp_ready && !run_end, rsp_valid && !unit_first && (unit_type == $past(unit_type)), "run broken")

endmodule

bind h264_annexb_nal_splitter_core h264nal_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .payload_byte (rsp_if.payload_byte),
   .unit_type    (rsp_if.unit_type),
   .unit_first   (rsp_if.unit_first),
   .unit_last    (rsp_if.unit_last),
   .run_end      (rsp_if.run_end)
);
